// ----- sv/tcw_pkg.sv -----
// tcw_pkg: shared types and constants for the text console character writer.
// Holds the item structs and the command classes passed from front to back.
// No dependencies.
package tcw_pkg;

   localparam int FUNC_W = 2;
   localparam int CHAR_W = 8;
   localparam int ROW_W  = 5;
   localparam int COL_W  = 7;

   localparam logic [FUNC_W-1:0] FUNC_PUT    = 2'd0;
   localparam logic [FUNC_W-1:0] FUNC_READ   = 2'd1;
   localparam logic [FUNC_W-1:0] FUNC_CLEAR  = 2'd2;
   localparam logic [FUNC_W-1:0] FUNC_UNUSED = 2'd3;

   localparam logic [CHAR_W-1:0] CHAR_BS = 8'd8;
   localparam logic [CHAR_W-1:0] CHAR_LF = 8'd10;
   localparam logic [CHAR_W-1:0] CHAR_CR = 8'd13;

   typedef struct packed {
      logic [FUNC_W-1:0] func;
      logic [CHAR_W-1:0] char_code;
      logic [ROW_W-1:0]  read_row;
      logic [COL_W-1:0]  read_col;
   } req_type;

   typedef struct packed {
      logic [ROW_W-1:0]  cursor_row;
      logic [COL_W-1:0]  cursor_col;
      logic [CHAR_W-1:0] cell_char;
   } rsp_type;

   typedef enum logic [2:0] {
      CMD_PUT,
      CMD_BACKSPACE,
      CMD_NEWLINE,
      CMD_READ,
      CMD_CLEAR,
      CMD_NOP
   } cmd_kind_type;

   typedef struct packed {
      cmd_kind_type      kind;
      logic [CHAR_W-1:0] ch;
      logic [ROW_W-1:0]  row;
      logic [COL_W-1:0]  col;
   } cmd_type;

endpackage

// ----- sv/tcw_front.sv -----
// tcw_front: accepts items, classifies them and queues them for the back end.
// Two-entry queue; busy while full.
// Depends on tcw_pkg.
module tcw_front (
   input  logic              clock,
   input  logic              reset,
   input  logic              start,
   output logic              busy,
   input  tcw_pkg::req_type  req_item,
   output logic              cmd_valid,
   output tcw_pkg::cmd_type  cmd,
   input  logic              cmd_ready
);

   tcw_pkg::cmd_type q_ff [2];
   logic       wr_ptr_ff, wr_ptr_in;
   logic       rd_ptr_ff, rd_ptr_in;
   logic [1:0] count_ff, count_in;
   tcw_pkg::cmd_type  cls;
   logic       push, pop;

   // classify
   always_comb begin
      cls.ch  = req_item.char_code;
      cls.row = req_item.read_row;
      cls.col = req_item.read_col;
      unique case (req_item.func)
         tcw_pkg::FUNC_PUT: begin
            if (req_item.char_code == tcw_pkg::CHAR_BS) begin
               cls.kind = tcw_pkg::CMD_BACKSPACE;
            end else if (req_item.char_code == tcw_pkg::CHAR_LF ||
                         req_item.char_code == tcw_pkg::CHAR_CR) begin
               cls.kind = tcw_pkg::CMD_NEWLINE;
            end else begin
               cls.kind = tcw_pkg::CMD_PUT;
            end
         end
         tcw_pkg::FUNC_READ:  cls.kind = tcw_pkg::CMD_READ;
         tcw_pkg::FUNC_CLEAR: cls.kind = tcw_pkg::CMD_CLEAR;
         default:             cls.kind = tcw_pkg::CMD_NOP;
      endcase
   end

   assign busy      = (count_ff == 2'd2);
   assign push      = start && !busy;
   assign cmd_valid = (count_ff != 2'd0);
   assign pop       = cmd_valid && cmd_ready;
   assign cmd       = q_ff[rd_ptr_ff];

   always_comb begin
      wr_ptr_in = wr_ptr_ff ^ push;
      rd_ptr_in = rd_ptr_ff ^ pop;
      count_in  = count_ff + {1'b0, push} - {1'b0, pop};
   end

   always_ff @(posedge clock) begin
      if (push) begin
         q_ff[wr_ptr_ff] <= cls;
      end
      if (reset) begin
         wr_ptr_ff <= 1'b0;
         rd_ptr_ff <= 1'b0;
         count_ff  <= 2'd0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

endmodule

// ----- sv/tcw_back.sv -----
// tcw_back: carries out queued commands on the screen store and cursor.
// Owns the character memory, the per-row last-column registers and the sweeps.
// Depends on tcw_pkg.
module tcw_back #(
   parameter int ROWS = 30,
   parameter int COLS = 80
) (
   input  logic              clock,
   input  logic              reset,
   input  logic              cmd_valid,
   input  tcw_pkg::cmd_type  cmd,
   output logic              cmd_ready,
   output logic              rsp_strobe,
   output tcw_pkg::rsp_type  rsp_item
);

   localparam int NCELLS   = ROWS * COLS;
   localparam int AW       = $clog2(NCELLS);
   localparam int RW       = $clog2(ROWS);
   localparam int CW       = $clog2(COLS);
   localparam int LAST_SCR = (ROWS - 1) * COLS;

   typedef enum logic [5:0] {
      ST_IDLE     = 6'b000001,
      ST_READ     = 6'b000010,
      ST_CLEAR    = 6'b000100,
      ST_SCR_RD   = 6'b001000,
      ST_SCR_WR   = 6'b010000,
      ST_SCR_BLNK = 6'b100000
   } state_type;

   state_type state_ff, state_in;
   logic [AW-1:0] idx_ff, idx_in;
   logic [RW-1:0] row_ff, row_in;
   logic [CW-1:0] col_ff, col_in;
   logic [CW-1:0] rlc_ff [ROWS];
   logic [CW-1:0] rlc_in [ROWS];
   logic          rsp_strobe_ff, rsp_strobe_in;
   tcw_pkg::rsp_type rsp_ff, rsp_in;

   logic [tcw_pkg::CHAR_W-1:0] mem [NCELLS];
   logic [tcw_pkg::CHAR_W-1:0] rd_data_ff;
   logic                       we;
   logic [AW-1:0]              wa, ra;
   logic [tcw_pkg::CHAR_W-1:0] wd;

   logic          do_nl, rsp_now;
   logic [CW-1:0] nl_val;
   logic [RW-1:0] prev_row;
   logic [AW-1:0] cur_addr;

   assign prev_row  = row_ff - 1'b1;
   assign cur_addr  = AW'(int'(row_ff) * COLS + int'(col_ff));
   assign cmd_ready = (state_ff == ST_IDLE);

   always_comb begin
      state_in      = state_ff;
      idx_in        = idx_ff;
      row_in        = row_ff;
      col_in        = col_ff;
      rlc_in        = rlc_ff;
      rsp_strobe_in = 1'b0;
      rsp_in        = rsp_ff;
      we            = 1'b0;
      wa            = cur_addr;
      wd            = '0;
      ra            = AW'(int'(idx_ff) + COLS);
      do_nl         = 1'b0;
      nl_val        = '0;
      rsp_now       = 1'b0;

      unique case (state_ff)
         ST_IDLE: begin
            if (cmd_valid) begin
               rsp_now = 1'b1;
               unique case (cmd.kind)
                  tcw_pkg::CMD_PUT: begin
                     we = 1'b1;
                     wd = cmd.ch;
                     if (int'(col_ff) == COLS - 1) begin
                        do_nl  = 1'b1;
                        nl_val = col_ff;
                     end else begin
                        col_in = col_ff + 1'b1;
                     end
                  end
                  tcw_pkg::CMD_BACKSPACE: begin
                     if (col_ff != '0) begin
                        col_in = col_ff - 1'b1;
                        we     = 1'b1;
                        wa     = AW'(int'(row_ff) * COLS + int'(col_ff) - 1);
                     end else if (row_ff != '0) begin
                        row_in = prev_row;
                        col_in = rlc_ff[prev_row];
                        we     = 1'b1;
                        wa     = AW'(int'(prev_row) * COLS + int'(rlc_ff[prev_row]));
                     end
                  end
                  tcw_pkg::CMD_NEWLINE: begin
                     do_nl  = 1'b1;
                     nl_val = (col_ff != '0) ? col_ff - 1'b1 : '0;
                  end
                  tcw_pkg::CMD_READ: begin
                     if (int'(cmd.row) < ROWS && int'(cmd.col) < COLS) begin
                        ra       = AW'(int'(cmd.row) * COLS + int'(cmd.col));
                        state_in = ST_READ;
                        rsp_now  = 1'b0;
                     end
                  end
                  tcw_pkg::CMD_CLEAR: begin
                     row_in = '0;
                     col_in = '0;
                     for (int r = 0; r < ROWS; r++) rlc_in[r] = '0;
                     idx_in   = '0;
                     state_in = ST_CLEAR;
                  end
                  default: ;
               endcase

               if (do_nl) begin
                  col_in = '0;
                  if (int'(row_ff) == ROWS - 1) begin
                     // bottom row: shift row ends up, keep the new end on the bottom
                     for (int r = 0; r < ROWS - 1; r++) rlc_in[r] = rlc_ff[r + 1];
                     rlc_in[ROWS-1] = nl_val;
                     idx_in   = '0;
                     state_in = ST_SCR_RD;
                  end else begin
                     rlc_in[row_ff] = nl_val;
                     row_in         = row_ff + 1'b1;
                  end
               end

               if (rsp_now) begin
                  rsp_strobe_in     = 1'b1;
                  rsp_in.cursor_row = tcw_pkg::ROW_W'(row_in);
                  rsp_in.cursor_col = tcw_pkg::COL_W'(col_in);
                  rsp_in.cell_char  = '0;
               end
            end
         end
         ST_READ: begin
            rsp_strobe_in     = 1'b1;
            rsp_in.cursor_row = tcw_pkg::ROW_W'(row_ff);
            rsp_in.cursor_col = tcw_pkg::COL_W'(col_ff);
            rsp_in.cell_char  = rd_data_ff;
            state_in          = ST_IDLE;
         end
         ST_CLEAR: begin
            we     = 1'b1;
            wa     = idx_ff;
            idx_in = idx_ff + 1'b1;
            if (int'(idx_ff) == NCELLS - 1) state_in = ST_IDLE;
         end
         ST_SCR_RD: begin
            state_in = ST_SCR_WR;
         end
         ST_SCR_WR: begin
            we     = 1'b1;
            wa     = idx_ff;
            wd     = rd_data_ff;
            idx_in = idx_ff + 1'b1;
            state_in = (int'(idx_ff) == LAST_SCR - 1) ? ST_SCR_BLNK : ST_SCR_RD;
         end
         ST_SCR_BLNK: begin
            we     = 1'b1;
            wa     = idx_ff;
            idx_in = idx_ff + 1'b1;
            if (int'(idx_ff) == NCELLS - 1) state_in = ST_IDLE;
         end
         default: state_in = ST_IDLE;
      endcase
   end

   // character store
   always_ff @(posedge clock) begin
      if (we) begin
         mem[wa] <= wd;
      end
      rd_data_ff <= mem[ra];
   end

   always_ff @(posedge clock) begin
      rsp_ff <= rsp_in;
      if (reset) begin
         state_ff      <= ST_CLEAR;
         idx_ff        <= '0;
         row_ff        <= '0;
         col_ff        <= '0;
         rsp_strobe_ff <= 1'b0;
         for (int r = 0; r < ROWS; r++) rlc_ff[r] <= '0;
      end else begin
         state_ff      <= state_in;
         idx_ff        <= idx_in;
         row_ff        <= row_in;
         col_ff        <= col_in;
         rsp_strobe_ff <= rsp_strobe_in;
         rlc_ff        <= rlc_in;
      end
   end

   assign rsp_strobe = rsp_strobe_ff;
   assign rsp_item   = rsp_ff;

endmodule

// ----- sv/text_console_char_writer.sv -----
// text_console_char_writer: text-mode console with cursor, backspace and scroll.
// Items answer via the queue and registered strobe; in-range reads also pass the
// read state and the registered read port. A clear zeroes ROWS*COLS cells; a scroll
// copies (ROWS-1)*COLS cells, a read and a write state each, then blanks COLS cells.
// Reset: a clearing pass zeroes all ROWS*COLS cells; items queue meanwhile.
// The receiver cannot stall; the 2-entry queue sets busy while full.
module text_console_char_writer #(
   parameter int ROWS = 30,
   parameter int COLS = 80
) (
   input  logic             clock,
   input  logic             reset,
   input  logic             start,
   output logic             busy,
   input  tcw_pkg::req_type req_item,
   output logic             rsp_strobe,
   output tcw_pkg::rsp_type rsp_item
);

   // classified commands between front and back
   logic             cmd_valid;
   logic             cmd_ready;
   tcw_pkg::cmd_type cmd;

   // front: decode item kind, buffer up to two items
   tcw_front u_front (
      .clock     (clock),
      .reset     (reset),
      .start     (start),
      .busy      (busy),
      .req_item  (req_item),
      .cmd_valid (cmd_valid),
      .cmd       (cmd),
      .cmd_ready (cmd_ready)
   );

   // back: screen store, cursor, row ends, clear and scroll sweeps
   tcw_back #(
      .ROWS (ROWS),
      .COLS (COLS)
   ) u_back (
      .clock      (clock),
      .reset      (reset),
      .cmd_valid  (cmd_valid),
      .cmd        (cmd),
      .cmd_ready  (cmd_ready),
      .rsp_strobe (rsp_strobe),
      .rsp_item   (rsp_item)
   );

endmodule

// ----- sim/tb_text_console_char_writer.sv -----
// Testbench for text_console_char_writer: drives put, read, clear and unused
// items, checks every result against a predictor of the console kept here.
// Depends on tcw_pkg and text_console_char_writer.
module tb_text_console_char_writer;

   localparam int ROWS = 30;
   localparam int COLS = 80;

   logic             clock;
   logic             reset;
   logic             start;
   logic             busy;
   tcw_pkg::req_type req_item;
   logic             rsp_strobe;
   tcw_pkg::rsp_type rsp_item;

   // predictor copy of the console
   logic [tcw_pkg::CHAR_W-1:0] screen [ROWS*COLS];
   logic [tcw_pkg::COL_W-1:0]  last_col [ROWS];
   int                         crow;
   int                         ccol;

   tcw_pkg::rsp_type expected_rsps[$];
   int               error_count;
   int               rsp_count;

   text_console_char_writer #(.ROWS(ROWS), .COLS(COLS)) dut (
      .clock(clock), .reset(reset), .start(start), .busy(busy),
      .req_item(req_item), .rsp_strobe(rsp_strobe), .rsp_item(rsp_item)
   );

   initial begin
      clock = 1'b0;
      forever #1 clock = ~clock;
   end

   // hard stop well past the slowest legal run: every item scrolling the store
   initial begin
      #200000000;
      $display("Testbench completed WITH ERRORS");
      $finish;
   end

   function automatic void console_home();
      for (int i = 0; i < ROWS*COLS; i++) screen[i] = '0;
      for (int r = 0; r < ROWS; r++) last_col[r] = '0;
      crow = 0;
      ccol = 0;
   endfunction

   // end the current line; scroll when on the bottom row
   function automatic void console_newline();
      last_col[crow] = (ccol > 0) ? tcw_pkg::COL_W'(ccol - 1) : '0;
      if (crow + 1 >= ROWS) begin
         for (int r = 0; r + 1 < ROWS; r++) begin
            last_col[r] = last_col[r+1];
            for (int c = 0; c < COLS; c++) screen[r*COLS+c] = screen[(r+1)*COLS+c];
         end
         for (int c = 0; c < COLS; c++) screen[(ROWS-1)*COLS+c] = '0;
         crow = ROWS - 1;
      end else begin
         crow++;
      end
      ccol = 0;
   endfunction

   function automatic tcw_pkg::rsp_type console_step(tcw_pkg::req_type rq);
      tcw_pkg::rsp_type rs;
      logic [tcw_pkg::CHAR_W-1:0] cell_val;
      cell_val = '0;
      if (rq.func == tcw_pkg::FUNC_PUT) begin
         if (rq.char_code == tcw_pkg::CHAR_BS) begin
            if (ccol == 0) begin
               if (crow > 0) begin
                  crow--;
                  ccol = last_col[crow];
                  if (ccol >= COLS) ccol = COLS - 1;
                  screen[crow*COLS+ccol] = '0;
               end
            end else begin
               ccol--;
               screen[crow*COLS+ccol] = '0;
            end
         end else if (rq.char_code == tcw_pkg::CHAR_LF ||
                      rq.char_code == tcw_pkg::CHAR_CR) begin
            console_newline();
         end else begin
            screen[crow*COLS+ccol] = rq.char_code;
            ccol++;
            if (ccol >= COLS) console_newline();
         end
      end else if (rq.func == tcw_pkg::FUNC_READ) begin
         if (rq.read_row < ROWS && rq.read_col < COLS)
            cell_val = screen[rq.read_row*COLS+rq.read_col];
      end else if (rq.func == tcw_pkg::FUNC_CLEAR) begin
         console_home();
      end
      rs.cursor_row = tcw_pkg::ROW_W'(crow);
      rs.cursor_col = tcw_pkg::COL_W'(ccol);
      rs.cell_char  = cell_val;
      return rs;
   endfunction

   // results cannot be held off: check on every strobe
   always @(posedge clock) begin
      tcw_pkg::rsp_type want;
      if (!reset && rsp_strobe) begin
         rsp_count++;
         if (expected_rsps.size() == 0) begin
            error_count++;
            $display("%0t: unexpected result %h", $time, rsp_item);
         end else begin
            want = expected_rsps.pop_front();
            if (rsp_item.cursor_row !== want.cursor_row) begin
               error_count++;
               $display("%0t: cursor_row expected %0d actual %0d",
                        $time, want.cursor_row, rsp_item.cursor_row);
            end
            if (rsp_item.cursor_col !== want.cursor_col) begin
               error_count++;
               $display("%0t: cursor_col expected %0d actual %0d",
                        $time, want.cursor_col, rsp_item.cursor_col);
            end
            if (rsp_item.cell_char !== want.cell_char) begin
               error_count++;
               $display("%0t: cell_char expected %h actual %h",
                        $time, want.cell_char, rsp_item.cell_char);
            end
         end
      end
   end

   // send one item after a random gap; prediction is made on acceptance.
   // start stays high on return so a zero gap follows back to back.
   task automatic send_item(logic [tcw_pkg::FUNC_W-1:0] f,
                            logic [tcw_pkg::CHAR_W-1:0] ch,
                            logic [tcw_pkg::ROW_W-1:0] r,
                            logic [tcw_pkg::COL_W-1:0] c);
      tcw_pkg::req_type rq;
      int gap;
      rq.func = f;
      rq.char_code = ch;
      rq.read_row = r;
      rq.read_col = c;
      gap = $urandom_range(0, 7);
      if ($urandom_range(0, 3) == 0) gap = 0;
      if (gap != 0) begin
         start <= 1'b0;
         req_item <= tcw_pkg::req_type'($urandom);
         repeat (gap) @(posedge clock);
      end
      start <= 1'b1;
      req_item <= rq;
      @(posedge clock);
      while (busy) @(posedge clock);
      expected_rsps.push_back(console_step(rq));
   endtask

   task automatic put_char(logic [tcw_pkg::CHAR_W-1:0] ch);
      send_item(tcw_pkg::FUNC_PUT, ch, tcw_pkg::ROW_W'($urandom),
                tcw_pkg::COL_W'($urandom));
   endtask

   task automatic read_cell(int r, int c);
      send_item(tcw_pkg::FUNC_READ, tcw_pkg::CHAR_W'($urandom),
                tcw_pkg::ROW_W'(r), tcw_pkg::COL_W'(c));
   endtask

   // any byte that is none of the control codes
   function automatic logic [tcw_pkg::CHAR_W-1:0] plain_char();
      logic [tcw_pkg::CHAR_W-1:0] ch;
      do ch = tcw_pkg::CHAR_W'($urandom);
      while (ch == tcw_pkg::CHAR_BS || ch == tcw_pkg::CHAR_LF || ch == tcw_pkg::CHAR_CR);
      return ch;
   endfunction

   task automatic test_directed();
      put_char(8'hFF);
      put_char(8'h00);
      put_char(8'h41);
      read_cell(0, 0);
      read_cell(ROWS-1, COLS-1);
      read_cell(31, 127);         // out of range both ways
      put_char(tcw_pkg::CHAR_BS);
      put_char(tcw_pkg::CHAR_BS);
      put_char(tcw_pkg::CHAR_BS); // third backspace reaches column zero
      put_char(tcw_pkg::CHAR_CR); // new line from column zero
      put_char(tcw_pkg::CHAR_BS); // back onto the empty row above, to its column zero
      put_char(tcw_pkg::CHAR_LF);
      send_item(tcw_pkg::FUNC_UNUSED, 8'hFF, 5'h1F, 7'h7F);
      send_item(tcw_pkg::FUNC_CLEAR, 8'h00, 5'd0, 7'd0);
      read_cell(0, 0);
   endtask

   // fill a line to the right edge, then back across the wrap
   task automatic test_wrap();
      for (int i = 0; i < COLS; i++) put_char(plain_char());
      read_cell(0, COLS-1);
      put_char(tcw_pkg::CHAR_BS);
      put_char(tcw_pkg::CHAR_BS);
      read_cell(0, COLS-2);
   endtask

   // walk to the bottom row and scroll a few times
   task automatic test_scroll();
      for (int i = 0; i < ROWS + 3; i++) begin
         put_char(plain_char());
         put_char(($urandom_range(0, 1) != 0) ? tcw_pkg::CHAR_LF : tcw_pkg::CHAR_CR);
      end
      read_cell(ROWS-2, 0);
      read_cell(ROWS-1, 0);
      put_char(tcw_pkg::CHAR_BS);
   endtask

   // mostly text with control codes and reads mixed in
   task automatic test_random(int count);
      int k;
      for (int i = 0; i < count; i++) begin
         k = $urandom_range(0, 99);
         if (k < 55) put_char(plain_char());
         else if (k < 65) put_char(tcw_pkg::CHAR_BS);
         else if (k < 70)
            put_char(($urandom_range(0, 1) != 0) ? tcw_pkg::CHAR_LF : tcw_pkg::CHAR_CR);
         else if (k < 92) read_cell($urandom_range(0, ROWS-1), $urandom_range(0, COLS-1));
         else if (k < 95) read_cell($urandom_range(0, 31), $urandom_range(0, 127));
         else if (k < 97) put_char(tcw_pkg::CHAR_W'($urandom));
         else if (k < 98) send_item(tcw_pkg::FUNC_UNUSED, tcw_pkg::CHAR_W'($urandom),
                                    tcw_pkg::ROW_W'($urandom), tcw_pkg::COL_W'($urandom));
         else send_item(tcw_pkg::FUNC_CLEAR, tcw_pkg::CHAR_W'($urandom),
                        tcw_pkg::ROW_W'($urandom), tcw_pkg::COL_W'($urandom));
      end
   endtask

   initial begin
      error_count = 0;
      rsp_count = 0;
      console_home();
      start = 1'b0;
      req_item = '0;
      reset = 1'b1;
      repeat (3) @(posedge clock);
      reset <= 1'b0;

      test_directed();
      test_wrap();
      test_scroll();
      test_random(1750);
      start <= 1'b0;

      // drain, then allow the slowest scroll to finish
      while (expected_rsps.size() != 0) @(posedge clock);
      repeat (10000) @(posedge clock);

      if (error_count == 0 && expected_rsps.size() == 0) begin
         $display("Testbench completed without errors");
      end else begin
         $display("Testbench completed WITH ERRORS");
      end
      $finish;
   end

endmodule

// ----- files.f -----
sv/tcw_pkg.sv
sv/tcw_front.sv
sv/tcw_back.sv
sv/text_console_char_writer.sv
sim/tb_text_console_char_writer.sv
